// File: rtl/core/modbus_meter_response_receiver_assert.svh
// Assertion macros shared by the receiver's RTL files.
`ifndef MODBUS_METER_RESPONSE_RECEIVER_ASSERT_SVH
`define MODBUS_METER_RESPONSE_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MMRR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MMRR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mmrr_pkg.sv
// Shared types, constants and the CRC step for the meter response receiver.
package mmrr_pkg;

  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned RAM_DEPTH   = 2 * STORE_DEPTH;
  localparam int unsigned RAM_AW      = IDX_W + 1;

  localparam logic [7:0]  FAIL_ADDRESS      = 8'hF8;
  localparam logic [7:0]  RST_DEVICE_ADDR   = 8'h01;
  localparam logic [7:0]  RST_FUNCTION_CODE = 8'h04;
  localparam logic [15:0] RST_CRC_POLY      = 16'hA001;
  localparam logic [15:0] RST_CRC_INIT      = 16'hFFFF;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_FUNCTION_CODE  = 2'd1,
    CFG_CRC_POLYNOMIAL = 2'd2,
    CFG_CRC_INITIAL    = 2'd3
  } cfg_index_t;

  // Handed from the frame parser to the unload unit when a frame ends.
  typedef struct packed {
    logic       valid;
    logic       crc_ok;
    logic [7:0] address;
    logic [7:0] length;
    logic       bank;
  } frame_done_t;

  // Reflected CRC-16 update of one byte, one bit per step.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/mmrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/mmrr_parser.sv
// Frame parser: configuration registers, frame phase tracking, CRC and payload writes.
module mmrr_parser
  import mmrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              unload_ready,
  output frame_done_t       done,
  output logic              wr_en,
  output logic [RAM_AW-1:0] wr_addr,
  output logic [7:0]        wr_data
);

  typedef enum logic [5:0] {
    PH_ADDR = 6'b000001,
    PH_FUNC = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRCL = 6'b010000,
    PH_CRCH = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  dev_addr_r, func_code_r;
  logic [15:0] crc_poly_r, crc_init_r;
  logic [7:0]  exp_len_r, exp_len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  frame_addr_r, frame_addr_nxt;
  logic        bank_r, bank_nxt;
  logic        accept;
  logic [15:0] crc_step;

  // Only the CRC high byte has to wait, and only while the previous result is unloading.
  assign in_stall  = (phase_r == PH_CRCH) && !unload_ready;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign crc_step  = crc_fold(crc_r, in_rx_byte, crc_poly_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= RST_DEVICE_ADDR;
      func_code_r <= RST_FUNCTION_CODE;
      crc_poly_r  <= RST_CRC_POLY;
      crc_init_r  <= RST_CRC_INIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEVICE_ADDRESS: dev_addr_r  <= cfg_data[7:0];
        CFG_FUNCTION_CODE:  func_code_r <= cfg_data[7:0];
        CFG_CRC_POLYNOMIAL: crc_poly_r  <= cfg_data;
        CFG_CRC_INITIAL:    crc_init_r  <= cfg_data;
      endcase
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    exp_len_nxt    = exp_len_r;
    cnt_nxt        = cnt_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    frame_addr_nxt = frame_addr_r;
    bank_nxt       = bank_r;
    wr_en          = 1'b0;
    wr_addr        = {bank_r, cnt_r[IDX_W-1:0]};
    wr_data        = in_rx_byte;
    done.valid     = 1'b0;
    done.crc_ok    = ({in_rx_byte, crc_lo_r} == crc_r);
    done.address   = frame_addr_r;
    done.length    = exp_len_r;
    done.bank      = bank_r;
    if (accept) begin
      unique case (phase_r)
        PH_FUNC: begin
          // A wrong function byte is skipped; the parser keeps waiting here.
          if (in_rx_byte == func_code_r) begin
            crc_nxt   = crc_step;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          exp_len_nxt = in_rx_byte;
          crc_nxt     = crc_step;
          cnt_nxt     = 8'h00;
          phase_nxt   = (in_rx_byte == 8'h00) ? PH_CRCL : PH_DATA;
        end
        PH_DATA: begin
          wr_en   = (cnt_r[7:IDX_W] == '0);
          crc_nxt = crc_step;
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt == exp_len_r) begin
            phase_nxt = PH_CRCL;
          end
        end
        PH_CRCL: begin
          crc_lo_nxt = in_rx_byte;
          phase_nxt  = PH_CRCH;
        end
        PH_CRCH: begin
          done.valid = 1'b1;
          bank_nxt   = ~bank_r;
          phase_nxt  = PH_ADDR;
        end
        default: begin
          phase_nxt = PH_ADDR;
          if (in_rx_byte == dev_addr_r) begin
            frame_addr_nxt = in_rx_byte;
            crc_nxt        = crc_fold(crc_init_r, in_rx_byte, crc_poly_r);
            phase_nxt      = PH_FUNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ADDR;
      exp_len_r    <= 8'h00;
      cnt_r        <= 8'h00;
      crc_r        <= RST_CRC_INIT;
      crc_lo_r     <= 8'h00;
      frame_addr_r <= 8'h00;
      bank_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      exp_len_r    <= exp_len_nxt;
      cnt_r        <= cnt_nxt;
      crc_r        <= crc_nxt;
      crc_lo_r     <= crc_lo_nxt;
      frame_addr_r <= frame_addr_nxt;
      bank_r       <= bank_nxt;
    end
  end

endmodule

// File: rtl/core/mmrr_unload.sv
// Unload unit: sweeps a finished frame's bank out of the RAM and builds the result item.
module mmrr_unload
  import mmrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  frame_done_t       done,
  output logic              ready,
  output logic              rd_en,
  output logic [RAM_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_frame_ok,
  output logic [7:0]        out_reply_address,
  output logic [7:0]        out_payload_length,
  output logic [15:0]       out_voltage_raw,
  output logic [31:0]       out_current_raw,
  output logic [31:0]       out_power_raw,
  output logic [31:0]       out_energy_raw,
  output logic [15:0]       out_frequency_raw
);

  `include "modbus_meter_response_receiver_assert.svh"

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_READ = 3'b010,
    U_LOAD = 3'b100
  } ustate_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  ustate_t          state_r, state_nxt;
  frame_done_t      info_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rd_pend_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [7:0]       asm_r [STORE_DEPTH];
  logic             out_valid_r, out_valid_nxt;
  logic             load_en;
  logic             byte_in_frame;

  logic        frame_ok_r;
  logic [7:0]  reply_address_r, payload_length_r;
  logic [15:0] voltage_r, frequency_r;
  logic [31:0] current_r, power_r, energy_r;

  assign ready   = (state_r == U_IDLE);
  assign rd_en   = (state_r == U_READ);
  assign rd_addr = {info_r.bank, idx_r};
  assign load_en = (state_r == U_LOAD) && !rd_pend_r && (!out_valid_r || !out_stall);
  // Bytes past the length byte were not written by this frame and read as zero.
  assign byte_in_frame = ({{(8-IDX_W){1'b0}}, rd_idx_r} < info_r.length);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      U_IDLE: begin
        if (done.valid) begin
          idx_nxt   = '0;
          state_nxt = U_READ;
        end
      end
      U_READ: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = U_LOAD;
        end
      end
      U_LOAD: begin
        if (load_en) begin
          out_valid_nxt = 1'b1;
          state_nxt     = U_IDLE;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= U_IDLE;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && done.valid) begin
      info_r <= done;
    end
    if (rd_en) begin
      rd_idx_r <= idx_r;
    end
    if (rd_pend_r) begin
      asm_r[rd_idx_r] <= byte_in_frame ? rd_data : 8'h00;
    end
    if (load_en) begin
      frame_ok_r       <= info_r.crc_ok;
      payload_length_r <= info_r.length;
      if (info_r.crc_ok) begin
        reply_address_r <= info_r.address;
        voltage_r       <= {asm_r[0], asm_r[1]};
        current_r       <= {asm_r[4], asm_r[5], asm_r[2], asm_r[3]};
        power_r         <= {asm_r[8], asm_r[9], asm_r[6], asm_r[7]};
        energy_r        <= {asm_r[12], asm_r[13], asm_r[10], asm_r[11]};
        frequency_r     <= {asm_r[14], asm_r[15]};
      end else begin
        reply_address_r <= FAIL_ADDRESS;
        voltage_r       <= 16'h0000;
        current_r       <= 32'h0000_0000;
        power_r         <= 32'h0000_0000;
        energy_r        <= 32'h0000_0000;
        frequency_r     <= 16'h0000;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_ok       = frame_ok_r;
  assign out_reply_address  = reply_address_r;
  assign out_payload_length = payload_length_r;
  assign out_voltage_raw    = voltage_r;
  assign out_current_raw    = current_r;
  assign out_power_raw      = power_r;
  assign out_energy_raw     = energy_r;
  assign out_frequency_raw  = frequency_r;

  `MMRR_ASSERT_IMP(a_done_only_idle, done.valid, state_r == U_IDLE, "frame end while unloading")
  `MMRR_ASSERT_NXT(a_sweep_starts, done.valid, state_r == U_READ, "sweep did not start")
  `MMRR_ASSERT_IMP(a_last_byte_in_load, rd_pend_r && (rd_idx_r == LAST_IDX),
                   state_r == U_LOAD, "last byte arrived outside the load state")

endmodule

// File: rtl/core/modbus_meter_response_receiver.sv
// Top level of the Modbus meter response receiver: parser, payload RAM and unload unit.
//
// Usage: received serial bytes enter on in_valid/in_rx_byte, one item per byte; an item is
// taken at an edge where in_valid is high and in_stall is low. The parser looks for the
// configured device address, the function code, a length byte, the payload and the CRC
// (low byte first). Each completed frame gives one result item on the out_ channel.
// Bytes are taken at one per cycle. The only byte that can stall is the CRC high byte,
// which waits while the previous frame is still being unloaded.
// Payload bytes are kept in a 32 x 8 RAM split into two banks, one per frame in turn.
// After the CRC high byte is taken, the unload unit reads all 16 bytes of the frame's bank
// through the RAM read port, waits for the registered read data and loads the result item.
// A following frame end is taken only once the unload unit is idle again.
// When out_stall is high the result holds in the output register while the parser keeps
// taking bytes of the next frame. Configuration registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data by the user only while the block is idle;
// the block does not enforce this. Reset (rst_n low, synchronous) restores address 1,
// function 4, polynomial 0xA001 and initial value 0xFFFF and starts hunting for an address.
module modbus_meter_response_receiver
  import mmrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [7:0]  out_reply_address,
  output logic [7:0]  out_payload_length,
  output logic [15:0] out_voltage_raw,
  output logic [31:0] out_current_raw,
  output logic [31:0] out_power_raw,
  output logic [31:0] out_energy_raw,
  output logic [15:0] out_frequency_raw,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "modbus_meter_response_receiver_assert.svh"

  frame_done_t       done;
  logic              unload_ready;
  logic              wr_en, rd_en;
  logic [RAM_AW-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  mmrr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .unload_ready (unload_ready),
    .done         (done),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  mmrr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mmrr_unload u_unload (
    .clk                (clk),
    .rst_n              (rst_n),
    .done               (done),
    .ready              (unload_ready),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_ok       (out_frame_ok),
    .out_reply_address  (out_reply_address),
    .out_payload_length (out_payload_length),
    .out_voltage_raw    (out_voltage_raw),
    .out_current_raw    (out_current_raw),
    .out_power_raw      (out_power_raw),
    .out_energy_raw     (out_energy_raw),
    .out_frequency_raw  (out_frequency_raw)
  );

  // The bank being filled and the bank being swept must never be the same.
  `MMRR_ASSERT_IMP(a_bank_split, wr_en && rd_en, wr_addr[RAM_AW-1] != rd_addr[RAM_AW-1],
                   "payload write hit the bank under unload")

endmodule
